// ===== src/gvm_pkg.sv =====
package gvm_pkg;

  // Q.30 fixed-point constants of the exponential
  localparam int unsigned Q30_W  = 31;
  localparam int unsigned X_W    = 38;   // 3*(h/range)^2 in Q.30, capped at 192.0
  localparam int unsigned N_W    = 9;    // integer part of x/ln2, at most 276
  localparam int unsigned K_W    = 4;    // series term index, 1..12
  localparam int unsigned REC_W  = 33;   // ceil(2^32/k)
  localparam int unsigned TERMS  = 12;

  localparam logic [Q30_W-1:0] Q30_ONE = 31'h4000_0000;
  localparam logic [X_W-1:0]   LN2_Q30 = 38'd744261118;
  // floor(2^X_W / LN2_Q30): (x * this) >> X_W is x/ln2, low by at most one
  localparam logic [N_W-1:0]   LN2_RECIP = 9'd369;

  // Datapath operations issued by the controller
  typedef enum logic [3:0] {
    OP_NONE,
    OP_LOAD,
    OP_ORIGIN,
    OP_EXTRAP,
    OP_DIV,
    OP_SQ,
    OP_X,
    OP_NDIV,
    OP_NSUB,
    OP_NFIX,
    OP_HMUL,
    OP_HREC,
    OP_HUPD,
    OP_CSUB,
    OP_PMUL,
    OP_EMIT
  } dp_op_e;

  typedef struct packed {
    logic run_start;
    logic last;
    logic special;   // zero lag or zero range: no evaluation needed
    logic out_free;  // output register can take a row this cycle
  } gvm_status_t;

  // ceil(2^32 / k) for the series divisors
  function automatic logic [REC_W-1:0] recip(input logic [K_W-1:0] k);
    logic [REC_W-1:0] r;
    case (k)
      4'd1:    r = 33'd4294967296;
      4'd2:    r = 33'd2147483648;
      4'd3:    r = 33'd1431655766;
      4'd4:    r = 33'd1073741824;
      4'd5:    r = 33'd858993460;
      4'd6:    r = 33'd715827883;
      4'd7:    r = 33'd613566757;
      4'd8:    r = 33'd536870912;
      4'd9:    r = 33'd477218589;
      4'd10:   r = 33'd429496730;
      4'd11:   r = 33'd390451573;
      4'd12:   r = 33'd357913942;
      default: r = '0;
    endcase
    return r;
  endfunction

endpackage

// ===== src/gaussian_variogram_model.sv =====
// Gaussian variogram model. Lag distances (unsigned, FRAC_BITS fraction bits)
// come in one item at a time; model rows (distance, value) go out in order,
// value = nugget + sill*(1 - exp(-3*(h/model_range)^2)), saturated. The first
// lag of a run is preceded by an origin row (0, nugget); the lag flagged
// last_lag produces no row of its own but an extrapolated final row
// (2*prev - older, prev value) with last_row set. One item is in flight at a
// time: a new lag is taken only once the last is through. A lag that needs the
// full evaluation goes through the bit-serial divider (WORD_BITS+FRAC_BITS
// steps), the 3-step ln2 reduction and the 12-term exp series, each term a
// multiply, a reciprocal multiply and an update. A zero lag or zero range
// skips the evaluation. The controller waits while the output is stalled.
// Registers: 0 nugget, 1 sill, 2 model_range; write only while idle.
module gaussian_variogram_model #(
  parameter int unsigned WORD_BITS = 32,
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  // config write
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [1:0]           cfg_index_i,
  input  logic [WORD_BITS-1:0] cfg_data_i,
  // lag items
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  logic [WORD_BITS-1:0] lag_distance_i,
  input  logic                 last_lag_i,
  // row items
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output logic [WORD_BITS-1:0] row_distance_o,
  output logic [WORD_BITS-1:0] row_value_o,
  output logic                 last_row_o
);

  localparam int unsigned CNT_W = $clog2(WORD_BITS + FRAC_BITS);

  localparam logic [1:0] REG_NUGGET = 2'd0;
  localparam logic [1:0] REG_SILL   = 2'd1;
  localparam logic [1:0] REG_RANGE  = 2'd2;
  localparam logic [WORD_BITS-1:0] ONE_FX = WORD_BITS'(1) << FRAC_BITS;

  logic [WORD_BITS-1:0] nugget_q, sill_q, range_q;

  gvm_pkg::gvm_status_t status;
  gvm_pkg::dp_op_e      op;
  logic [CNT_W-1:0]     cnt;

  // config always accepted; writes to an unused index are dropped
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      nugget_q <= '0;
      sill_q   <= ONE_FX;
      range_q  <= ONE_FX;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        REG_NUGGET: nugget_q <= cfg_data_i;
        REG_SILL:   sill_q   <= cfg_data_i;
        REG_RANGE:  range_q  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  gvm_ctrl #(
    .WORD_BITS(WORD_BITS),
    .FRAC_BITS(FRAC_BITS),
    .CNT_W    (CNT_W)
  ) u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid_i(in_valid_i),
    .in_stall_o(in_stall_o),
    .status_i  (status),
    .op_o      (op),
    .cnt_o     (cnt)
  );

  gvm_dp #(
    .WORD_BITS(WORD_BITS),
    .FRAC_BITS(FRAC_BITS),
    .CNT_W    (CNT_W)
  ) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .op_i          (op),
    .cnt_i         (cnt),
    .status_o      (status),
    .nugget_i      (nugget_q),
    .sill_i        (sill_q),
    .range_i       (range_q),
    .lag_distance_i(lag_distance_i),
    .last_lag_i    (last_lag_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .row_distance_o(row_distance_o),
    .row_value_o   (row_value_o),
    .last_row_o    (last_row_o)
  );

endmodule

// ===== src/gvm_ctrl.sv =====
module gvm_ctrl #(
  parameter int unsigned WORD_BITS = 32,
  parameter int unsigned FRAC_BITS = 16,
  parameter int unsigned CNT_W     = 6
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  gvm_pkg::gvm_status_t status_i,
  output gvm_pkg::dp_op_e      op_o,
  output logic [CNT_W-1:0]     cnt_o
);

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_ORIGIN = 4'd1;
  localparam logic [3:0] S_EXTRAP = 4'd2;
  localparam logic [3:0] S_DIV    = 4'd3;
  localparam logic [3:0] S_SQ     = 4'd4;
  localparam logic [3:0] S_X      = 4'd5;
  localparam logic [3:0] S_NDIV   = 4'd6;
  localparam logic [3:0] S_HMUL   = 4'd7;
  localparam logic [3:0] S_HREC   = 4'd8;
  localparam logic [3:0] S_HUPD   = 4'd9;
  localparam logic [3:0] S_CSUB   = 4'd10;
  localparam logic [3:0] S_PMUL   = 4'd11;
  localparam logic [3:0] S_EMIT   = 4'd12;
  localparam logic [3:0] S_NSUB   = 4'd13;
  localparam logic [3:0] S_NFIX   = 4'd14;

  localparam logic [CNT_W-1:0] DIV_LAST = CNT_W'(WORD_BITS + FRAC_BITS - 1);
  localparam logic [CNT_W-1:0] K_TOP    = CNT_W'(gvm_pkg::TERMS);

  logic [3:0]       state_q, state_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;

  assign in_stall_o = (state_q != S_IDLE);
  assign cnt_o      = cnt_q;

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    op_o    = gvm_pkg::OP_NONE;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          op_o    = gvm_pkg::OP_LOAD;
          state_d = S_ORIGIN;
        end
      end
      S_ORIGIN: begin
        if (!status_i.run_start || status_i.out_free) begin
          if (status_i.run_start) op_o = gvm_pkg::OP_ORIGIN;
          cnt_d = DIV_LAST;
          if (status_i.last) state_d = S_EXTRAP;
          else if (status_i.special) state_d = S_EMIT;
          else state_d = S_DIV;
        end
      end
      S_EXTRAP: begin
        if (status_i.out_free) begin
          op_o    = gvm_pkg::OP_EXTRAP;
          state_d = S_IDLE;
        end
      end
      S_DIV: begin
        op_o  = gvm_pkg::OP_DIV;
        cnt_d = cnt_q - 1'b1;
        if (cnt_q == '0) state_d = S_SQ;
      end
      S_SQ: begin
        op_o    = gvm_pkg::OP_SQ;
        state_d = S_X;
      end
      S_X: begin
        op_o    = gvm_pkg::OP_X;
        state_d = S_NDIV;
      end
      S_NDIV: begin
        op_o    = gvm_pkg::OP_NDIV;
        state_d = S_NSUB;
      end
      S_NSUB: begin
        op_o    = gvm_pkg::OP_NSUB;
        state_d = S_NFIX;
      end
      S_NFIX: begin
        op_o    = gvm_pkg::OP_NFIX;
        cnt_d   = K_TOP;
        state_d = S_HMUL;
      end
      S_HMUL: begin
        op_o    = gvm_pkg::OP_HMUL;
        state_d = S_HREC;
      end
      S_HREC: begin
        op_o    = gvm_pkg::OP_HREC;
        state_d = S_HUPD;
      end
      S_HUPD: begin
        op_o  = gvm_pkg::OP_HUPD;
        cnt_d = cnt_q - 1'b1;
        if (cnt_q == CNT_W'(1)) state_d = S_CSUB;
        else state_d = S_HMUL;
      end
      S_CSUB: begin
        op_o    = gvm_pkg::OP_CSUB;
        state_d = S_PMUL;
      end
      S_PMUL: begin
        op_o    = gvm_pkg::OP_PMUL;
        state_d = S_EMIT;
      end
      S_EMIT: begin
        if (status_i.out_free) begin
          op_o    = gvm_pkg::OP_EMIT;
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

endmodule

// ===== src/gvm_dp.sv =====
module gvm_dp #(
  parameter int unsigned WORD_BITS = 32,
  parameter int unsigned FRAC_BITS = 16,
  parameter int unsigned CNT_W     = 6
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  gvm_pkg::dp_op_e      op_i,
  input  logic [CNT_W-1:0]     cnt_i,
  output gvm_pkg::gvm_status_t status_o,
  input  logic [WORD_BITS-1:0] nugget_i,
  input  logic [WORD_BITS-1:0] sill_i,
  input  logic [WORD_BITS-1:0] range_i,
  input  logic [WORD_BITS-1:0] lag_distance_i,
  input  logic                 last_lag_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output logic [WORD_BITS-1:0] row_distance_o,
  output logic [WORD_BITS-1:0] row_value_o,
  output logic                 last_row_o
);

  localparam int unsigned W    = WORD_BITS;
  localparam int unsigned F    = FRAC_BITS;
  localparam int unsigned DV_W = W + F;
  localparam int unsigned T_W  = F + 4;
  localparam int unsigned SQ_W = 2 * T_W;
  localparam int unsigned S_W  = SQ_W - F;
  localparam int unsigned QW   = gvm_pkg::Q30_W;
  localparam int unsigned XW   = gvm_pkg::X_W;
  localparam int unsigned NW   = gvm_pkg::N_W;
  localparam int unsigned NP_W = XW + NW;
  localparam int unsigned PM_W = W + QW;
  localparam logic [T_W-1:0] CAP     = T_W'(8) << F;
  localparam logic [W-1:0]   ALL_ONE = '1;

  // control state
  logic run_start_q, out_valid_q;
  // run history
  logic [W-1:0] prev_dist_q, older_dist_q, prev_val_q;
  // item and evaluation registers
  logic [W-1:0]    h_q, rem_q;
  logic            last_q;
  logic [DV_W-1:0] dvd_q;
  logic [T_W-1:0]  t_q;
  logic [SQ_W-1:0] sq_q;
  logic [XW-1:0]   nrem_q;
  logic [NW-1:0]   n_q;
  logic [QW-1:0]   p_q, m_q, qe_q, c_q;
  logic [PM_W-1:0] pm_q;
  logic [W-1:0]    row_dist_q, row_val_q;
  logic            row_last_q;

  logic out_free;
  logic out_set;
  assign out_free = !out_valid_q || !out_stall_i;
  assign out_set  = op_i inside {gvm_pkg::OP_ORIGIN, gvm_pkg::OP_EXTRAP, gvm_pkg::OP_EMIT};

  assign status_o.run_start = run_start_q;
  assign status_o.last      = last_q;
  assign status_o.special   = (h_q == '0) || (range_i == '0);
  assign status_o.out_free  = out_free;

  assign out_valid_o    = out_valid_q;
  assign row_distance_o = row_dist_q;
  assign row_value_o    = row_val_q;
  assign last_row_o     = row_last_q;

  // restoring divide step of h*2^F / range
  logic [W:0]     rem_sh;
  logic           div_ge;
  logic [W-1:0]   rem_nx;
  logic [T_W:0]   t_sh;
  logic [T_W-1:0] t_nx;
  always_comb begin
    rem_sh = {rem_q, dvd_q[DV_W-1]};
    div_ge = (rem_sh >= {1'b0, range_i});
    rem_nx = div_ge ? W'(rem_sh - {1'b0, range_i}) : rem_sh[W-1:0];
    t_sh   = {t_q, div_ge};
    t_nx   = t_q;
    if (t_q < CAP) begin
      t_nx = (t_sh > {1'b0, CAP}) ? CAP : t_sh[T_W-1:0];
    end
  end

  // x = 3*floor(t^2/2^F) moved to Q.30
  logic [S_W-1:0] s_val;
  logic [XW-1:0]  x_val;
  assign s_val = sq_q[SQ_W-1:F];
  assign x_val = (XW'(s_val) * XW'(3)) << (30 - F);

  // x / ln2: reciprocal estimate (low by at most one), remainder, one fix-up
  logic [NP_W-1:0] nest_prod;
  logic [XW-1:0]   nln2_prod;
  logic            nfix_ge;
  assign nest_prod = NP_W'(nrem_q) * NP_W'(gvm_pkg::LN2_RECIP);
  assign nln2_prod = XW'(n_q) * gvm_pkg::LN2_Q30;
  assign nfix_ge   = (nrem_q >= gvm_pkg::LN2_Q30);

  // Horner term: p = 1 - floor(floor(r*p/2^30) / k)
  logic [gvm_pkg::K_W-1:0] k_val;
  logic [2*QW-1:0]         rp_prod;
  logic [63:0]             rec_prod;
  logic [QW+3:0]           qk;
  logic [QW-1:0]           q_fix;
  assign k_val    = cnt_i[gvm_pkg::K_W-1:0];
  assign rp_prod  = (2*QW)'(nrem_q[29:0]) * (2*QW)'(p_q);
  assign rec_prod = 64'(m_q) * 64'(gvm_pkg::recip(k_val));
  assign qk       = (QW+4)'(qe_q) * (QW+4)'(k_val);
  assign q_fix    = (qk > (QW+4)'(m_q)) ? qe_q - 1'b1 : qe_q;

  // c = 1 - exp(-x)
  logic [QW-1:0] e_val;
  assign e_val = (n_q >= NW'(QW)) ? '0 : (p_q >> n_q);

  // row value
  logic [W:0]   sum_special, sum_eval;
  logic [W-1:0] val_special, val_eval, val_row;
  assign sum_special = {1'b0, nugget_i} + {1'b0, sill_i};
  assign val_special = sum_special[W] ? ALL_ONE : sum_special[W-1:0];
  assign sum_eval    = {1'b0, nugget_i} + {1'b0, pm_q[W+29:30]};
  assign val_eval    = sum_eval[W] ? ALL_ONE : sum_eval[W-1:0];
  always_comb begin
    if (h_q == '0) val_row = nugget_i;
    else if (range_i == '0) val_row = val_special;
    else val_row = val_eval;
  end

  // extrapolated distance 2*prev - older, clamped
  logic [W+1:0] ext_sum;
  logic [W-1:0] ext_dist;
  assign ext_sum = ({2'b00, prev_dist_q} << 1) - {2'b00, older_dist_q};
  always_comb begin
    if (ext_sum[W+1]) ext_dist = '0;
    else if (ext_sum[W]) ext_dist = ALL_ONE;
    else ext_dist = ext_sum[W-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_start_q  <= 1'b1;
      out_valid_q  <= 1'b0;
      prev_dist_q  <= '0;
      older_dist_q <= '0;
      prev_val_q   <= '0;
    end else begin
      out_valid_q <= out_set || (out_valid_q && out_stall_i);
      case (op_i)
        gvm_pkg::OP_ORIGIN: begin
          run_start_q  <= 1'b0;
          prev_dist_q  <= '0;
          older_dist_q <= '0;
          prev_val_q   <= nugget_i;
        end
        gvm_pkg::OP_EXTRAP: begin
          run_start_q <= 1'b1;
        end
        gvm_pkg::OP_EMIT: begin
          older_dist_q <= prev_dist_q;
          prev_dist_q  <= h_q;
          prev_val_q   <= val_row;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    case (op_i)
      gvm_pkg::OP_LOAD: begin
        h_q    <= lag_distance_i;
        last_q <= last_lag_i;
        rem_q  <= '0;
        t_q    <= '0;
        dvd_q  <= {lag_distance_i, {F{1'b0}}};
      end
      gvm_pkg::OP_ORIGIN: begin
        row_dist_q <= '0;
        row_val_q  <= nugget_i;
        row_last_q <= 1'b0;
      end
      gvm_pkg::OP_EXTRAP: begin
        row_dist_q <= (run_start_q) ? '0 : ext_dist;
        row_val_q  <= (run_start_q) ? nugget_i : prev_val_q;
        row_last_q <= 1'b1;
      end
      gvm_pkg::OP_DIV: begin
        rem_q <= rem_nx;
        t_q   <= t_nx;
        dvd_q <= dvd_q << 1;
      end
      gvm_pkg::OP_SQ: sq_q <= SQ_W'(t_q) * SQ_W'(t_q);
      gvm_pkg::OP_X: begin
        nrem_q <= x_val;
        n_q    <= '0;
        p_q    <= gvm_pkg::Q30_ONE;
      end
      gvm_pkg::OP_NDIV: n_q    <= nest_prod[NP_W-1:XW];
      gvm_pkg::OP_NSUB: nrem_q <= nrem_q - nln2_prod;
      gvm_pkg::OP_NFIX: begin
        if (nfix_ge) begin
          nrem_q <= nrem_q - gvm_pkg::LN2_Q30;
          n_q    <= n_q + 1'b1;
        end
      end
      gvm_pkg::OP_HMUL: m_q  <= rp_prod[QW+29:30];
      gvm_pkg::OP_HREC: qe_q <= rec_prod[QW+31:32];
      gvm_pkg::OP_HUPD: p_q  <= gvm_pkg::Q30_ONE - q_fix;
      gvm_pkg::OP_CSUB: c_q  <= gvm_pkg::Q30_ONE - e_val;
      gvm_pkg::OP_PMUL: pm_q <= PM_W'(sill_i) * PM_W'(c_q);
      gvm_pkg::OP_EMIT: begin
        row_dist_q <= h_q;
        row_val_q  <= val_row;
        row_last_q <= 1'b0;
      end
      default: ;
    endcase
  end

endmodule
